// ===== rtl/lkhc_pkg.sv =====
// Package with the constants, register codes and result type of the header cipher.
`timescale 1ns / 1ps

package lkhc_pkg;

  // Keystream generator constants and the reset value of the plain-text limit.
  localparam logic [31:0] LCG_ADD     = 32'h3C6E_F35F;
  localparam logic [31:0] LCG_MULT    = 32'h0019_660D;
  localparam logic [31:0] LIMIT_RESET = 32'd1000000;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_DIRECTION   = 1'b0,
    REG_PLAIN_LIMIT = 1'b1
  } reg_idx_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        enc;
  } res_t;

endpackage

// ===== rtl/lcg_keystream_header_cipher.sv =====
// Top level of the LCG keystream header cipher with its configuration registers.
`timescale 1ns / 1ps

// Header cipher for a stream of 32-bit header words. The word flagged by
// in_start_req carries the header length; it and each further word are XORed with
// the next key of the LCG key = key * 0x0019660D + 0x3C6EF35F, started from zero.
// With direction 0 a first word above plain_limit marks an encrypted header
// (its length is the word XOR 0x3C6EF35F), otherwise words pass unchanged.
// With direction 1 the header is encrypted and its final slot carries the
// word sum XOR the last key. Exactly the counted number of results is
// produced; words outside a header are dropped. Direction and plain_limit are
// sampled at the start word. The block takes one word per clock cycle while
// in_ready is high: the key update (one constant multiply and add) is done in
// the cycle a word is accepted, and a two-entry output buffer lets input
// continue while a result waits to be taken. Result beats leave from a register.
module lcg_keystream_header_cipher (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic        in_start_req,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_last,
  output logic        out_was_encrypted,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic        dir_r;
  logic [31:0] limit_r;

  // Header state
  logic [31:0] key_r,   key_nxt;
  logic [31:0] sum_r,   sum_nxt;
  logic [31:0] left_r,  left_nxt;
  logic        cipher_r, cipher_nxt;
  logic        hdr_r,    hdr_nxt;
  logic        seal_r,   seal_nxt;

  // Output buffer
  logic                 out_valid_r;
  logic                 skid_valid_r;
  lkhc_pkg::res_t       out_r;
  lkhc_pkg::res_t       skid_r;
  lkhc_pkg::res_t       res;

  // Step signals
  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 cfg_wr;
  lkhc_pkg::reg_idx_t   cfg_idx;
  logic                 above;
  logic [31:0] key_cur;
  logic [31:0] sum_cur;
  logic [31:0] left_cur;
  logic        cipher_cur;
  logic        hdr_cur;
  logic        seal_cur;
  logic [31:0] key_step;

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = lkhc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      limit_r <= lkhc_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lkhc_pkg::REG_DIRECTION:   dir_r   <= pwdata[0];
        lkhc_pkg::REG_PLAIN_LIMIT: limit_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lkhc_pkg::REG_DIRECTION:   prdata = {31'd0, dir_r};
      lkhc_pkg::REG_PLAIN_LIMIT: prdata = limit_r;
      default:                   prdata = 32'd0;
    endcase
  end

  // Handshake: input stalls only when both buffer entries are full.
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;

  // A start word restarts the header state; otherwise the registers carry on.
  assign above = in_word > limit_r;

  always_comb begin
    if (in_start_req) begin
      key_cur    = 32'd0;
      sum_cur    = 32'd0;
      seal_cur   = dir_r;
      cipher_cur = dir_r || above;
      left_cur   = (!dir_r && above) ? (in_word ^ lkhc_pkg::LCG_ADD) : in_word;
      hdr_cur    = left_cur != 32'd0;
    end else begin
      key_cur    = key_r;
      sum_cur    = sum_r;
      seal_cur   = seal_r;
      cipher_cur = cipher_r;
      left_cur   = left_r;
      hdr_cur    = hdr_r;
    end
  end

  // Next keystream key, kept to 32 bits.
  assign key_step = 32'(key_cur * lkhc_pkg::LCG_MULT) + lkhc_pkg::LCG_ADD;

  // Transform of one word and the state it leaves behind.
  always_comb begin
    key_nxt    = key_cur;
    sum_nxt    = sum_cur;
    seal_nxt   = seal_cur;
    cipher_nxt = cipher_cur;
    left_nxt   = left_cur;
    hdr_nxt    = hdr_cur;
    res.word   = in_word;
    res.enc    = cipher_cur;
    res.last   = left_cur == 32'd1;
    if (hdr_cur) begin
      if (seal_cur) begin
        if (left_cur > 32'd1) begin
          sum_nxt  = sum_cur + in_word;
          key_nxt  = key_step;
          res.word = in_word ^ key_step;
        end else begin
          // Final slot of a header encrypted with direction 1 carries the checksum.
          res.word = sum_cur ^ key_cur;
        end
      end else if (cipher_cur) begin
        key_nxt  = key_step;
        res.word = in_word ^ key_step;
      end
      left_nxt = left_cur - 32'd1;
      hdr_nxt  = left_cur != 32'd1;
    end
  end

  assign push = accept && hdr_cur;

  // Header state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= 32'd0;
      sum_r    <= 32'd0;
      left_r   <= 32'd0;
      cipher_r <= 1'b0;
      hdr_r    <= 1'b0;
      seal_r   <= 1'b0;
    end else if (accept) begin
      key_r    <= key_nxt;
      sum_r    <= sum_nxt;
      left_r   <= left_nxt;
      cipher_r <= cipher_nxt;
      hdr_r    <= hdr_nxt;
      seal_r   <= seal_nxt;
    end
  end

  // Output buffer: main register plus one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_word          = out_r.word;
  assign out_last          = out_r.last;
  assign out_was_encrypted = out_r.enc;

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  // A header in progress always owes at least one result.
  a_hdr_owes: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r |-> (left_r != 32'd0))
    else $error("header open with no words left");

  // An encrypting header always applies the keystream.
  a_seal_cipher: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_r && seal_r) |-> cipher_r)
    else $error("encrypt header without keystream");

  // A dropped word leaves the buffer occupancy untouched.
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !hdr_cur && !pop) |=> (out_valid_r == $past(out_valid_r)))
    else $error("dropped word produced a result");

endmodule
